// ===== design/bis_pkg.sv =====
// ----------------------------------------------------------------------------
// bis_pkg
// Shared constants for the bounded integer set: field widths, default
// capacity and operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bis_pkg;

  localparam int CAPACITY_DEF = 128;
  localparam int VALUE_W      = 32;
  localparam int OPCODE_W     = 2;
  localparam int COUNT_W      = 8;

  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

`default_nettype wire

// ===== design/bis_store.sv =====
// ----------------------------------------------------------------------------
// bis_store
// Entry store: one write port and one read port, read data registered.
// Contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_store #(
  parameter int DEPTH = bis_pkg::CAPACITY_DEF,
  parameter int IDX_W = 7
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [IDX_W-1:0]           wr_addr,
  input  wire logic [bis_pkg::VALUE_W-1:0] wr_data,
  input  wire logic                       rd_en,
  input  wire logic [IDX_W-1:0]           rd_addr,
  output logic      [bis_pkg::VALUE_W-1:0] rd_data
);

  logic [bis_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/bounded_integer_set.sv =====
// ----------------------------------------------------------------------------
// bounded_integer_set
// Fixed-capacity set of signed 32-bit integers kept unsorted in a memory,
// searched linearly, with remove filling the hole from the last entry.
// ----------------------------------------------------------------------------
// Sequence: after the accepting edge the block scans the live entries
//   (0..CAPACITY), one per cycle through the store's single read port,
//   stopping at a match; a remove that finds its value then moves the last entry.
// Throughput: one transaction at a time; in_stall is high until the result is loaded.
// Reset: clears the live count and control state; the store is not cleared.
`default_nettype none

module bounded_integer_set #(
  parameter int CAPACITY = bis_pkg::CAPACITY_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic        [bis_pkg::OPCODE_W-1:0] opcode,
  input  wire logic signed [bis_pkg::VALUE_W-1:0]  value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   status,
  output logic                                   was_member,
  output logic             [bis_pkg::COUNT_W-1:0]  count
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RESOLVE,
    S_MOVE,
    S_DONE
  } state_t;

  state_t                        state;
  logic [bis_pkg::OPCODE_W-1:0]  op_q;
  logic [bis_pkg::VALUE_W-1:0]   val_q;
  logic [CNT_W-1:0]              live_count;
  logic [IDX_W-1:0]              cmp_idx;
  logic [IDX_W-1:0]              slot;
  logic                          found;
  logic                          status_q;

  logic                          wr_en;
  logic [IDX_W-1:0]              wr_addr;
  logic [bis_pkg::VALUE_W-1:0]   wr_data;
  logic                          rd_en;
  logic [IDX_W-1:0]              rd_addr;
  logic [bis_pkg::VALUE_W-1:0]   rd_data;

  logic                          accept;
  logic                          last_cmp;
  logic                          is_full;
  logic [IDX_W-1:0]              last_idx;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign last_cmp = ((CNT_W'(cmp_idx) + 1'b1) == live_count);
  assign is_full  = (live_count == CNT_W'(CAPACITY));
  assign last_idx = IDX_W'(live_count - 1'b1);

  // Memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = IDX_W'(live_count);
    wr_data = val_q;
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state)
      S_IDLE: begin
        rd_en   = accept;
        rd_addr = '0;
      end
      S_SCAN: begin
        rd_en   = (rd_data != val_q) && !last_cmp;
        rd_addr = cmp_idx + 1'b1;
      end
      S_RESOLVE: begin
        if (op_q == bis_pkg::OP_INSERT && !found && !is_full) begin
          wr_en   = 1'b1;
          wr_addr = IDX_W'(live_count);
        end
        rd_en   = (op_q == bis_pkg::OP_REMOVE) && found;
        rd_addr = last_idx;
      end
      S_MOVE: begin
        // fill the hole with the former last entry
        wr_en   = (slot != last_idx);
        wr_addr = slot;
        wr_data = rd_data;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      live_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      // in S_DONE the output register is reloaded below instead
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q     <= opcode;
            val_q    <= value;
            cmp_idx  <= '0;
            found    <= 1'b0;
            status_q <= bis_pkg::STATUS_OK;
            state    <= (live_count == '0) ? S_RESOLVE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_data == val_q) begin
            found <= 1'b1;
            slot  <= cmp_idx;
            state <= S_RESOLVE;
          end else if (last_cmp) begin
            state <= S_RESOLVE;
          end else begin
            cmp_idx <= cmp_idx + 1'b1;
          end
        end
        S_RESOLVE: begin
          state <= S_DONE;
          case (op_q)
            bis_pkg::OP_INSERT: begin
              if (!found) begin
                if (is_full) begin
                  status_q <= bis_pkg::STATUS_FULL;
                end else begin
                  live_count <= live_count + 1'b1;
                end
              end
            end
            bis_pkg::OP_REMOVE: begin
              if (found) begin
                state <= S_MOVE;
              end
            end
            default: begin
            end
          endcase
        end
        S_MOVE: begin
          live_count <= live_count - 1'b1;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            status     <= status_q;
            was_member <= found;
            count      <= bis_pkg::COUNT_W'(live_count);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  bis_store #(
    .DEPTH (CAPACITY),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

// ===== tb/bounded_integer_set_check.sv =====
// ----------------------------------------------------------------------------
// bounded_integer_set_check
// Watches both channels of the bounded integer set, keeps its own copy of
// the set, predicts status, prior membership and count for every accepted
// transaction, and compares each returned result against the oldest one due.
// ----------------------------------------------------------------------------
module bounded_integer_set_check #(
  parameter int CAPACITY = bis_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic        [bis_pkg::OPCODE_W-1:0]  opcode,
  input  logic signed [bis_pkg::VALUE_W-1:0]   value,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic                                 status,
  input  logic                                 was_member,
  input  logic        [bis_pkg::COUNT_W-1:0]   count,
  output int                                   mismatches,
  output int                                   pending,
  output int                                   refused,
  output int                                   peak
);

  typedef struct packed {
    logic                        status;
    logic                        was_member;
    logic [bis_pkg::COUNT_W-1:0] count;
  } set_result_t;

  logic signed [bis_pkg::VALUE_W-1:0] members [CAPACITY];
  int                                 live;
  set_result_t                        results_due [$];

  initial begin
    mismatches = 0;
    pending    = 0;
    refused    = 0;
    peak       = 0;
    live       = 0;
  end

  // Apply one operation to the shadow set and return what the block must report.
  function automatic set_result_t apply_set_op(logic [bis_pkg::OPCODE_W-1:0] op,
                                               logic signed [bis_pkg::VALUE_W-1:0] v);
    set_result_t r;
    int          slot;
    slot = -1;
    for (int i = 0; i < live; i++)
      if (slot < 0 && members[i] == v) slot = i;
    r.was_member = (slot >= 0);
    r.status     = bis_pkg::STATUS_OK;
    case (op)
      bis_pkg::OP_INSERT: begin
        if (slot < 0) begin
          if (live >= CAPACITY) begin
            r.status = bis_pkg::STATUS_FULL;
            refused++;
          end else begin
            members[live] = v;
            live++;
          end
        end
      end
      bis_pkg::OP_REMOVE: begin
        // hole is filled from the last live entry
        if (slot >= 0) begin
          members[slot] = members[live-1];
          live--;
        end
      end
      default: ;
    endcase
    if (live > peak) peak = live;
    r.count = bis_pkg::COUNT_W'(live);
    return r;
  endfunction

  task automatic report(string field, int want, int got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin : watch
    set_result_t want;
    if (rst) begin
      live = 0;
      results_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with none due, expected nothing, got count %0d",
                   $time, count);
        end else begin
          want = results_due.pop_front();
          if (status !== want.status) report("status", want.status, status);
          if (was_member !== want.was_member)
            report("was_member", want.was_member, was_member);
          if (count !== want.count) report("count", want.count, count);
        end
      end
      if (in_valid && !in_stall)
        results_due.push_back(apply_set_op(opcode, value));
    end
    pending = results_due.size();
  end

endmodule

// ===== tb/bounded_integer_set_test.sv =====
// ----------------------------------------------------------------------------
// bounded_integer_set_test
// Drives the bounded integer set with a directed sequence of edge cases, then
// random transactions that fill the set past capacity, mix operations and
// drain it again, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module bounded_integer_set_test;

  localparam int                           POOL      = 150;
  localparam logic [bis_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam logic signed [bis_pkg::VALUE_W-1:0] VMIN = 32'sh8000_0000;
  localparam logic signed [bis_pkg::VALUE_W-1:0] VMAX = 32'sh7fff_ffff;

  logic                               clk;
  logic                               rst;
  logic                               in_valid;
  logic                               out_stall;
  logic [bis_pkg::OPCODE_W-1:0]       opcode;
  logic signed [bis_pkg::VALUE_W-1:0] value;
  wire                                in_stall;
  wire                                out_valid;
  wire                                status;
  wire                                was_member;
  wire [bis_pkg::COUNT_W-1:0]         count;

  int mismatches, pending, refused, peak;
  int sent, directed, stall_left, fill_idx, drain_idx;
  bit quiet;
  logic signed [bis_pkg::VALUE_W-1:0] pool [POOL];

  bounded_integer_set dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .was_member(was_member), .count(count)
  );

  bounded_integer_set_check check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .was_member(was_member), .count(count),
    .mismatches(mismatches), .pending(pending), .refused(refused), .peak(peak)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

  // result side back-pressure: random bursts of out_stall, none while quiet
  initial begin
    out_stall  = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_stall  = 0;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_stall = 1;
        stall_left--;
      end else if (out_stall) begin
        out_stall = 0;
      end else if ($urandom_range(3) == 0) begin
        out_stall  = 1;
        stall_left = $urandom_range(2);
      end
    end
  end

  task automatic idle_gap();
    if (!quiet && $urandom_range(3) == 0)
      repeat ($urandom_range(1, 3)) begin
        @(negedge clk);
        in_valid = 0;
        opcode   = bis_pkg::OPCODE_W'($urandom);
        value    = $urandom;
      end
  endtask

  task automatic send_op(logic [bis_pkg::OPCODE_W-1:0] op,
                         logic signed [bis_pkg::VALUE_W-1:0] v);
    idle_gap();
    @(negedge clk);
    in_valid = 1;
    opcode   = op;
    value    = v;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  function automatic logic signed [bis_pkg::VALUE_W-1:0] pick_value();
    if ($urandom_range(4) == 0) return $urandom;
    return pool[$urandom_range(POOL-1)];
  endfunction

  function automatic logic [bis_pkg::OPCODE_W-1:0] pick_op(int ins_pct, int rem_pct);
    int r;
    r = $urandom_range(99);
    if (r < ins_pct) return bis_pkg::OP_INSERT;
    if (r < ins_pct + rem_pct) return bis_pkg::OP_REMOVE;
    if (r < 97) return bis_pkg::OP_QUERY;
    return OP_UNUSED;
  endfunction

  task automatic wait_all_results();
    @(negedge clk);
    in_valid = 0;
    wait (pending == 0);
  endtask

  initial begin
    rst       = 1;
    in_valid  = 0;
    opcode    = bis_pkg::OP_QUERY;
    value     = 0;
    quiet     = 0;
    sent      = 0;
    fill_idx  = 0;
    drain_idx = 0;
    pool[0] = VMIN;
    pool[1] = VMAX;
    pool[2] = 0;
    pool[3] = -1;
    for (int i = 4; i < POOL; i++) pool[i] = $urandom;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed edge cases
    send_op(bis_pkg::OP_REMOVE, 5);          // remove on empty set
    send_op(bis_pkg::OP_QUERY, 5);
    send_op(bis_pkg::OP_INSERT, VMIN);
    send_op(bis_pkg::OP_INSERT, VMAX);
    send_op(bis_pkg::OP_INSERT, 0);
    send_op(bis_pkg::OP_INSERT, -1);
    send_op(bis_pkg::OP_INSERT, VMAX);       // already present
    send_op(bis_pkg::OP_QUERY, VMIN);
    send_op(bis_pkg::OP_QUERY, 12345);
    send_op(bis_pkg::OP_REMOVE, 777);        // absent
    send_op(bis_pkg::OP_REMOVE, VMIN);       // first slot, last entry moves in
    send_op(bis_pkg::OP_QUERY, -1);
    send_op(OP_UNUSED, 0);
    send_op(OP_UNUSED, 32'sh1234_5678);
    send_op(bis_pkg::OP_INSERT, 1);
    send_op(bis_pkg::OP_REMOVE, 1);          // last slot, nothing to move
    send_op(bis_pkg::OP_REMOVE, VMAX);
    send_op(bis_pkg::OP_REMOVE, 0);
    send_op(bis_pkg::OP_REMOVE, -1);
    send_op(bis_pkg::OP_QUERY, 0);
    directed = sent;
    wait_all_results();

    // fill past capacity: mostly walk the pool in order, which also revisits
    // members once full
    for (int n = 0; n < 170; n++) begin
      if (n % 25 == 0) quiet = ($urandom_range(3) == 0);
      if ($urandom_range(9) < 8) begin
        send_op(bis_pkg::OP_INSERT, pool[fill_idx]);
        fill_idx = (fill_idx + 1) % POOL;
      end else begin
        send_op(pick_op(40, 30), pick_value());
      end
    end
    quiet = 0;
    wait_all_results();

    for (int n = 0; n < 90; n++) begin
      if (n % 25 == 0) quiet = ($urandom_range(3) == 0);
      send_op(pick_op(40, 40), pick_value());
    end

    // drain; the tail runs without idling
    for (int n = 0; n < 150; n++) begin
      quiet = (n >= 90);
      if ($urandom_range(9) < 8) begin
        send_op(bis_pkg::OP_REMOVE, pool[drain_idx]);
        drain_idx = (drain_idx + 1) % POOL;
      end else begin
        send_op(pick_op(20, 40), pick_value());
      end
    end
    wait_all_results();
    repeat (140) @(posedge clk);

    $display("Ran %0d transactions (%0d directed): filled past capacity, then drained.",
             sent, directed);
    $display("Inserts refused as full: %0d; peak membership: %0d.", refused, peak);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
